/* src/field_line_time_to_samples_macros.svh */
// Assertion macros used by the port-level checker of the offset converter.
`ifndef FIELD_LINE_TIME_TO_SAMPLES_MACROS_SVH
`define FIELD_LINE_TIME_TO_SAMPLES_MACROS_SVH

// Check that is switched off while reset is high.
`define FLT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check that also runs across reset.
`define FLT_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* src/flt_pkg.sv */
// Types, constants and helper functions of the field/line/time offset converter.
package flt_pkg;

   // field widths of the words on the channels
   localparam int unsigned FieldW   = 4;
   localparam int unsigned LineW    = 11;
   localparam int unsigned TimeW    = 21;
   localparam int unsigned SampleW  = 31;

   // default depth of the queue between front and back
   localparam int unsigned QueueDepth = 4;

   // time scaling: s = trunc((864*t + 625) / 1250)
   localparam int unsigned NumW = 31;
   localparam logic signed [NumW-1:0] NUM_MUL  = 31'sd864;
   localparam logic signed [NumW-1:0] NUM_HALF = 31'sd625;
   // half of the numerator magnitude, divided by 625 through a reciprocal
   localparam int unsigned MagW       = 29;
   localparam int unsigned RecipW     = 30;
   localparam logic [RecipW-1:0] RECIP_K = 30'd879609303;
   localparam int unsigned RecipShift = 39;
   localparam int unsigned ProdW      = MagW + RecipW;
   localparam int unsigned QuotW      = ProdW - RecipShift;

   // placement in the frame
   localparam int unsigned FselW      = 2;
   localparam int unsigned LadjW      = 10;
   localparam int unsigned LoffW      = LineW + 1;
   localparam int unsigned LineLenW   = 19;
   localparam int unsigned LtermW     = 29;
   localparam int unsigned HalfW      = 28;
   localparam int unsigned FrameTermW = 30;
   localparam int unsigned SumW       = 32;

   localparam logic [SampleW-1:0] SAMPLE_MAX = 31'd1105920000;

   // 625-line constants
   localparam logic [QuotW-1:0]    P_TIME_MAX   = 20'd442367;
   localparam logic [HalfW-1:0]    P_HALF_FRAME = 28'd138240000;
   localparam logic [LineLenW-1:0] P_LINE_LEN   = 19'd442368;
   localparam logic [LoffW-1:0]    P_ODD_SHIFT  = 12'd313;
   localparam logic [LoffW-1:0]    P_NEG_ODD    = 12'd624;
   localparam logic [LoffW-1:0]    P_NEG_EVEN   = 12'd312;
   localparam logic [FieldW-1:0]   P_FIELD_WRAP = 4'd7;
   localparam logic signed [LineW-1:0] P_LINE_WIDE   = 11'sd312;
   localparam logic signed [LineW-1:0] P_LINE_NARROW = 11'sd311;

   // 525-line constants
   localparam logic [QuotW-1:0]    N_TIME_MAX   = 20'd439295;
   localparam logic [HalfW-1:0]    N_HALF_FRAME = 28'd115315200;
   localparam logic [LineLenW-1:0] N_LINE_LEN   = 19'd439296;
   localparam logic [LoffW-1:0]    N_ODD_SHIFT  = 12'd263;
   localparam logic [LoffW-1:0]    N_NEG_ODD    = 12'd524;
   localparam logic [LoffW-1:0]    N_NEG_EVEN   = 12'd262;
   localparam logic [FieldW-1:0]   N_FIELD_WRAP = 4'd3;
   localparam logic signed [LineW-1:0] N_LINE_WIDE   = 11'sd262;
   localparam logic signed [LineW-1:0] N_LINE_NARROW = 11'sd261;

   typedef enum logic {
      STD_625 = 1'b0,
      STD_525 = 1'b1
   } std_type;

   // per-word flags decided by the front
   typedef struct packed {
      logic    zero;
      logic    bad;
      logic    minus;
      logic    tzero;
      std_type std;
   } flags_type;

   // one queue entry
   typedef struct packed {
      flags_type         flags;
      logic [MagW-1:0]   mag;
      logic [FselW-1:0]  fsel;
      logic [LadjW-1:0]  ladj;
   } entry_type;

   function automatic logic [QuotW-1:0] time_max(std_type std);
      return (std == STD_525) ? N_TIME_MAX : P_TIME_MAX;
   endfunction

   function automatic logic [LineLenW-1:0] line_len(std_type std);
      return (std == STD_525) ? N_LINE_LEN : P_LINE_LEN;
   endfunction

   // start of the selected field pair: 2 * fsel half frames
   function automatic logic [FrameTermW-1:0] frame_term(std_type std,
                                                         logic [FselW-1:0] fsel);
      logic [FrameTermW-1:0] half;
      half = (std == STD_525) ? FrameTermW'(N_HALF_FRAME) : FrameTermW'(P_HALF_FRAME);
      return FrameTermW'({fsel, 1'b0}) * half;
   endfunction

endpackage

/* src/flt_if.sv */
// Channel interfaces of the offset converter: request words in, result words out.
interface flt_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [flt_pkg::FieldW-1:0]   field;
   logic signed [flt_pkg::LineW-1:0]    line;
   logic signed [flt_pkg::TimeW-1:0]    time_tenth_ns;

   modport source (output valid, output field, output line, output time_tenth_ns,
                   input ready);
   modport sink   (input valid, input field, input line, input time_tenth_ns,
                   output ready);
endinterface

interface flt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [flt_pkg::SampleW-1:0]   sample_offset;
   logic                          illegal;

   modport source (output valid, output sample_offset, output illegal, input ready);
   modport sink   (input valid, input sample_offset, input illegal, output ready);
endinterface

/* src/flt_front.sv */
// Front end: takes request words, checks sign and field/line limits, prepares queue entries.
module flt_front (
   input  flt_pkg::std_type    std,
   input  logic                queue_full,
   flt_req_if.sink             req_if,
   output logic                push,
   output flt_pkg::entry_type  push_entry
);

   logic signed [flt_pkg::FieldW-1:0] f;
   logic signed [flt_pkg::LineW-1:0]  l;
   logic signed [flt_pkg::TimeW-1:0]  t;
   logic                              f_le, l_le, t_le;
   logic                              all_le, all_ge, all_zero, minus;
   logic                              line_ok;
   logic signed [flt_pkg::NumW-1:0]   num;
   logic [flt_pkg::NumW-1:0]          num_mag;
   logic [flt_pkg::FieldW-1:0]        wrap;
   logic [flt_pkg::FieldW-1:0]        f_adj;
   logic [flt_pkg::LoffW-1:0]         l_off;
   logic [flt_pkg::LoffW-1:0]         l_sum;

   assign f = req_if.field;
   assign l = req_if.line;
   assign t = req_if.time_tenth_ns;

   // accept whenever the queue has room
   assign req_if.ready = !queue_full;
   assign push         = req_if.valid && !queue_full;

   // sign classification
   assign f_le     = f[flt_pkg::FieldW-1] || (f == '0);
   assign l_le     = l[flt_pkg::LineW-1]  || (l == '0);
   assign t_le     = t[flt_pkg::TimeW-1]  || (t == '0);
   assign all_le   = f_le && l_le && t_le;
   assign all_ge   = !f[flt_pkg::FieldW-1] && !l[flt_pkg::LineW-1] && !t[flt_pkg::TimeW-1];
   assign all_zero = (f == '0) && (l == '0) && (t == '0);
   assign minus    = all_le;

   // field and line limits per standard
   always_comb begin
      line_ok = 1'b0;
      if (std == flt_pkg::STD_625) begin
         case (f)
            4'sd0: line_ok = minus ? (l >= -flt_pkg::P_LINE_NARROW)
                                   : (l <= flt_pkg::P_LINE_WIDE);
            -4'sd1, -4'sd3, 4'sd2:
               line_ok = (l >= -flt_pkg::P_LINE_WIDE) && (l <= flt_pkg::P_LINE_WIDE);
            -4'sd2, 4'sd1, 4'sd3:
               line_ok = (l >= -flt_pkg::P_LINE_NARROW) && (l <= flt_pkg::P_LINE_NARROW);
            4'sd4:   line_ok = l_le && t_le;
            default: line_ok = 1'b0;
         endcase
      end else begin
         case (f)
            4'sd0: line_ok = minus ? (l >= -flt_pkg::N_LINE_NARROW)
                                   : (l <= flt_pkg::N_LINE_WIDE);
            -4'sd1:
               line_ok = (l >= -flt_pkg::N_LINE_WIDE) && (l <= flt_pkg::N_LINE_WIDE);
            4'sd1:
               line_ok = (l >= -flt_pkg::N_LINE_NARROW) && (l <= flt_pkg::N_LINE_NARROW);
            4'sd2:   line_ok = l_le && t_le;
            default: line_ok = 1'b0;
         endcase
      end
   end

   // time numerator and half its magnitude
   assign num     = flt_pkg::NumW'(t) * flt_pkg::NUM_MUL + flt_pkg::NUM_HALF;
   assign num_mag = num[flt_pkg::NumW-1] ? unsigned'(-num) : unsigned'(num);

   // wrap negative offsets into the frame, fold odd fields onto even ones
   always_comb begin
      wrap = '0;
      if (minus) begin
         wrap = (std == flt_pkg::STD_525) ? flt_pkg::N_FIELD_WRAP : flt_pkg::P_FIELD_WRAP;
      end
   end

   assign f_adj = unsigned'(f) + wrap;

   always_comb begin
      l_off = '0;
      if (std == flt_pkg::STD_525) begin
         if (minus) begin
            l_off = f_adj[0] ? flt_pkg::N_NEG_ODD : flt_pkg::N_NEG_EVEN;
         end else if (f_adj[0]) begin
            l_off = flt_pkg::N_ODD_SHIFT;
         end
      end else begin
         if (minus) begin
            l_off = f_adj[0] ? flt_pkg::P_NEG_ODD : flt_pkg::P_NEG_EVEN;
         end else if (f_adj[0]) begin
            l_off = flt_pkg::P_ODD_SHIFT;
         end
      end
   end

   assign l_sum = unsigned'(flt_pkg::LoffW'(l)) + l_off;

   // pack the entry
   always_comb begin
      push_entry.flags.zero  = all_zero;
      push_entry.flags.bad   = !all_zero && (!(all_le || all_ge) || !line_ok);
      push_entry.flags.minus = minus;
      push_entry.flags.tzero = (t == '0);
      push_entry.flags.std   = std;
      push_entry.mag         = num_mag[flt_pkg::MagW:1];
      push_entry.fsel        = f_adj[flt_pkg::FselW:1];
      push_entry.ladj        = l_sum[flt_pkg::LadjW-1:0];
   end

endmodule

/* src/flt_queue.sv */
// Small first-in first-out queue of classified words between front and back.
module flt_queue #(
   parameter int unsigned DEPTH = flt_pkg::QueueDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  flt_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output flt_pkg::entry_type  head_entry
);

   localparam int unsigned IdxW = $clog2(DEPTH);
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   flt_pkg::entry_type store [DEPTH];

   logic [IdxW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IdxW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff,  count_in;

   assign full       = (count_ff == CntW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = store[rd_ptr_ff];

   // write the entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         store[wr_ptr_ff] <= push_entry;
      end
   end

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* src/flt_back.sv */
// Back end: scales time, checks the time limit, places the offset in the frame.
module flt_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  flt_pkg::entry_type  head_entry,
   output logic                pop,
   flt_rsp_if.source           rsp_if
);

   // first stage: products
   logic                              s1_valid_ff, s1_valid_in;
   flt_pkg::flags_type                s1_flags_ff;
   logic [flt_pkg::ProdW-1:0]         s1_prod_ff;
   logic [flt_pkg::LtermW-1:0]        s1_lterm_ff;
   logic [flt_pkg::FrameTermW-1:0]    s1_fterm_ff;

   // second stage: result word
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [flt_pkg::SampleW-1:0]       rsp_sample_ff, rsp_sample_in;
   logic                              rsp_illegal_ff, rsp_illegal_in;

   logic                              out_free, s1_free;
   logic [flt_pkg::QuotW-1:0]         quot;
   logic                              time_bad;
   logic signed [flt_pkg::SumW-1:0]   s_term, total;

   // stall control
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign s1_free  = !s1_valid_ff || out_free;
   assign pop      = head_valid && s1_free;

   assign s1_valid_in  = s1_free ? head_valid : s1_valid_ff;
   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;

   // load products
   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_flags_ff <= head_entry.flags;
         s1_prod_ff  <= flt_pkg::ProdW'(head_entry.mag) * flt_pkg::ProdW'(flt_pkg::RECIP_K);
         s1_lterm_ff <= flt_pkg::LtermW'(head_entry.ladj)
                      * flt_pkg::LtermW'(flt_pkg::line_len(head_entry.flags.std));
         s1_fterm_ff <= flt_pkg::frame_term(head_entry.flags.std, head_entry.fsel);
      end
   end

   // quotient, time limit and final sum
   assign quot     = s1_prod_ff[flt_pkg::ProdW-1:flt_pkg::RecipShift];
   assign time_bad = quot > flt_pkg::time_max(s1_flags_ff.std);

   always_comb begin
      if (s1_flags_ff.minus) begin
         s_term = signed'(flt_pkg::SumW'(flt_pkg::time_max(s1_flags_ff.std)))
                - signed'(flt_pkg::SumW'(quot))
                + signed'(flt_pkg::SumW'(s1_flags_ff.tzero));
      end else begin
         s_term = signed'(flt_pkg::SumW'(quot));
      end
      total = s_term + signed'(flt_pkg::SumW'(s1_fterm_ff))
                     + signed'(flt_pkg::SumW'(s1_lterm_ff));
   end

   always_comb begin
      if (s1_flags_ff.zero) begin
         rsp_illegal_in = 1'b0;
         rsp_sample_in  = '0;
      end else if (s1_flags_ff.bad || time_bad || total[flt_pkg::SumW-1]) begin
         rsp_illegal_in = 1'b1;
         rsp_sample_in  = '0;
      end else begin
         rsp_illegal_in = 1'b0;
         rsp_sample_in  = total[flt_pkg::SampleW-1:0];
      end
   end

   // hold the result word until taken
   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_sample_ff  <= rsp_sample_in;
         rsp_illegal_ff <= rsp_illegal_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.sample_offset = rsp_sample_ff;
   assign rsp_if.illegal       = rsp_illegal_ff;

endmodule

/* src/field_line_time_to_samples.sv */
// Top level of the field/line/time offset to sample delay converter.
//
// Usage:
//   req_if carries one offset word (field, line, time_tenth_ns, all signed) under a
//   valid/ready handshake; rsp_if returns one word per request (sample_offset in
//   1/256 of a 27 MHz sample, illegal flag) in request order.
//   csr_wr_en/csr_wr_data write line_standard (0: 625-line, 1: 525-line); write it
//   only while no word is in flight.
//   Path: queue, multiply stage, result register, then rsp_if. Throughput: one
//   word per cycle while rsp_if.ready is high; the back end has one multiply stage
//   and one sum/compare stage, each taking a word every cycle unless stalled.
//   Stall: while rsp_if.ready is low the result word holds, the two back stages
//   fill, and the four-entry queue keeps taking words; req_if.ready drops only
//   when that queue is full.
//   Reset: synchronous; empties the queue and both back stages and sets
//   line_standard to 625-line timing. No clearing pass is needed.
module field_line_time_to_samples #(
   parameter int unsigned QUEUE_DEPTH = flt_pkg::QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   flt_req_if.sink    req_if,
   flt_rsp_if.source  rsp_if
);

   flt_pkg::std_type    line_standard_ff, line_standard_in;
   logic                push, queue_full, pop, head_valid;
   flt_pkg::entry_type  push_entry, head_entry;

   // configuration register
   assign line_standard_in = csr_wr_en ? flt_pkg::std_type'(csr_wr_data) : line_standard_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_standard_ff <= flt_pkg::STD_625;
      end else begin
         line_standard_ff <= line_standard_in;
      end
   end

   flt_front u_front (
      .std        (line_standard_ff),
      .queue_full (queue_full),
      .req_if     (req_if),
      .push       (push),
      .push_entry (push_entry)
   );

   flt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   flt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule

/* src/flt_checker.sv */
// Port-level checks of the offset converter, bound to the top level.
`include "field_line_time_to_samples_macros.svh"

module flt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [flt_pkg::SampleW-1:0]   rsp_sample_offset,
   input logic                          rsp_illegal
);

   // no result word right after reset
   `FLT_ASSERT_RST(a_rsp_idle_after_reset, $past(reset) |-> !rsp_valid, "result after reset")

   // a rejected offset carries zero delay
   `FLT_ASSERT(a_illegal_zero, rsp_valid && rsp_illegal |-> rsp_sample_offset == '0, "illegal with nonzero delay")

   // a legal delay does not exceed SAMPLE_MAX
   `FLT_ASSERT(a_delay_range, rsp_valid && !rsp_illegal |-> rsp_sample_offset <= flt_pkg::SAMPLE_MAX, "delay out of range")

   // a stalled result word holds
   `FLT_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_offset) && $stable(rsp_illegal), "stalled result changed")

endmodule

bind field_line_time_to_samples flt_checker u_flt_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_sample_offset (rsp_if.sample_offset),
   .rsp_illegal       (rsp_if.illegal)
);

/* sim/flt_delay_checker.sv */
// Checker of the offset converter: predicts each result word and compares it with the DUT.
`timescale 1ns / 1ps

module flt_delay_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   flt_req_if         req_mon,
   flt_rsp_if         rsp_mon,
   output int         pending_words,
   output int         fail_count
);

   // 0.6912 as a ratio, plus one half before truncation
   localparam longint SCALE_NUM  = 6912;
   localparam longint SCALE_DEN  = 10000;
   localparam longint SCALE_HALF = 5000;

   typedef struct {
      logic signed [flt_pkg::FieldW-1:0] field;
      logic signed [flt_pkg::LineW-1:0]  line;
      logic signed [flt_pkg::TimeW-1:0]  time_tenth_ns;
      logic [flt_pkg::SampleW-1:0]       sample_offset;
      logic                              illegal;
   } delay_expect_type;

   delay_expect_type   expected_delays[$];
   flt_pkg::std_type   line_std;

   // Compute the delay word for one offset under the given line standard.
   function automatic delay_expect_type predict_delay(
      input flt_pkg::std_type std,
      input logic signed [flt_pkg::FieldW-1:0] fld,
      input logic signed [flt_pkg::LineW-1:0] ln,
      input logic signed [flt_pkg::TimeW-1:0] tm);
      delay_expect_type word;
      longint f, l, t, s;
      longint tmax, half, llen, odd_shift, neg_odd, neg_even, wrap, wide, narrow;
      bit minus, fits;
      word.field = fld;
      word.line = ln;
      word.time_tenth_ns = tm;
      word.sample_offset = '0;
      word.illegal = 1'b1;
      f = fld;
      l = ln;
      t = tm;

      if (f == 0 && l == 0 && t == 0) begin
         word.illegal = 1'b0;
         return word;
      end
      if (f <= 0 && l <= 0 && t <= 0) begin
         minus = 1'b1;
      end else if (f >= 0 && l >= 0 && t >= 0) begin
         minus = 1'b0;
      end else begin
         return word;
      end

      s = (t * SCALE_NUM + SCALE_HALF) / SCALE_DEN;

      if (std == flt_pkg::STD_525) begin
         tmax = 439295; half = 115315200; llen = 439296;
         odd_shift = 263; neg_odd = 524; neg_even = 262; wrap = 3;
         wide = 262; narrow = 261;
      end else begin
         tmax = 442367; half = 138240000; llen = 442368;
         odd_shift = 313; neg_odd = 624; neg_even = 312; wrap = 7;
         wide = 312; narrow = 311;
      end

      if ((s < 0 ? -s : s) > tmax) return word;

      // field and line limits of each standard
      fits = 1'b0;
      if (std == flt_pkg::STD_525) begin
         case (f)
            0: fits = minus ? (l >= -narrow) : (l <= wide);
            -1: fits = (l < 0 ? -l : l) <= wide;
            1: fits = (l < 0 ? -l : l) <= narrow;
            2: fits = (l <= 0) && (t <= 0);
            default: fits = 1'b0;
         endcase
      end else begin
         case (f)
            0: fits = minus ? (l >= -narrow) : (l <= wide);
            -1, -3, 2: fits = (l < 0 ? -l : l) <= wide;
            -2, 1, 3: fits = (l < 0 ? -l : l) <= narrow;
            4: fits = (l <= 0) && (t <= 0);
            default: fits = 1'b0;
         endcase
      end
      if (!fits) return word;

      // shift odd fields, wrap negative offsets into the frame ahead
      if (!minus) begin
         if (f[0]) begin
            l += odd_shift;
            f -= 1;
         end
      end else begin
         f += wrap;
         s += tmax;
         if (f[0]) begin
            l += neg_odd;
            f -= 1;
         end else begin
            l += neg_even;
         end
         if (t == 0) s += 1;
      end
      s += f * half + l * llen;
      if (s < 0) return word;

      word.sample_offset = s[flt_pkg::SampleW-1:0];
      word.illegal = 1'b0;
      return word;
   endfunction

   // Retire result words, queue predictions, track the line standard.
   always @(posedge clock) begin
      delay_expect_type oldest;
      if (reset) begin
         expected_delays.delete();
         line_std = flt_pkg::STD_625;
         fail_count <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_delays.size() == 0) begin
               $display("%0t: unexpected result word, sample_offset %0d illegal %0b",
                        $time, rsp_mon.sample_offset, rsp_mon.illegal);
               fail_count <= fail_count + 1;
            end else begin
               oldest = expected_delays.pop_front();
               if (rsp_mon.sample_offset !== oldest.sample_offset ||
                   rsp_mon.illegal !== oldest.illegal) begin
                  fail_count <= fail_count + 1;
                  $display("%0t: offset field %0d line %0d time %0d", $time,
                           oldest.field, oldest.line, oldest.time_tenth_ns);
                  if (rsp_mon.sample_offset !== oldest.sample_offset)
                     $display("%0t: sample_offset mismatch, expected %0d, actual %0d",
                              $time, oldest.sample_offset, rsp_mon.sample_offset);
                  if (rsp_mon.illegal !== oldest.illegal)
                     $display("%0t: illegal mismatch, expected %0b, actual %0b",
                              $time, oldest.illegal, rsp_mon.illegal);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_delays.push_back(predict_delay(line_std, req_mon.field, req_mon.line,
                                                    req_mon.time_tenth_ns));
         if (csr_wr_en)
            line_std = flt_pkg::std_type'(csr_wr_data);
      end
      pending_words <= expected_delays.size();
   end

endmodule

/* sim/field_line_time_to_samples_tb.sv */
// Testbench top of the offset converter: clock, reset, stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module field_line_time_to_samples_tb;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;
   int   pending_words;
   int   fail_count;
   bit   no_idle;

   flt_req_if req_if ();
   flt_rsp_if rsp_if ();

   field_line_time_to_samples i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_if      (req_if),
      .rsp_if      (rsp_if)
   );

   flt_delay_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .pending_words (pending_words),
      .fail_count    (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Present one offset word after a random gap and hold it until accepted.
   task automatic send_offset(input logic signed [flt_pkg::FieldW-1:0] fld,
                              input logic signed [flt_pkg::LineW-1:0] ln,
                              input logic signed [flt_pkg::TimeW-1:0] tm);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.field <= fld;
      req_if.line <= ln;
      req_if.time_tenth_ns <= tm;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Stop sending and wait until every predicted word has come back.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   // Write the line standard with nothing in flight.
   task automatic write_standard(input flt_pkg::std_type std);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= std;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Draw an offset: mostly same-sign words near the legal limits, some noise.
   function automatic void pick_offset(input flt_pkg::std_type std,
                                       output logic signed [flt_pkg::FieldW-1:0] fld,
                                       output logic signed [flt_pkg::LineW-1:0] ln,
                                       output logic signed [flt_pkg::TimeW-1:0] tm);
      int  kind, fmax, fmag, lwide, lmag, tlim, tmag;
      bit  neg;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         fld = flt_pkg::FieldW'($urandom);
         ln = flt_pkg::LineW'($urandom);
         tm = flt_pkg::TimeW'($urandom);
         return;
      end
      neg = 1'($urandom_range(0, 1));
      if (std == flt_pkg::STD_525) begin
         fmax = neg ? 1 : 2;
         lwide = 262;
         tlim = 635556;
      end else begin
         fmax = neg ? 3 : 4;
         lwide = 312;
         tlim = 640001;
      end
      fmag = $urandom_range(0, fmax);
      lmag = $urandom_range(0, lwide + 1);
      case ($urandom_range(0, 3))
         0: tmag = $urandom_range(0, 20);
         1: tmag = tlim - $urandom_range(0, 3);
         default: tmag = $urandom_range(0, tlim);
      endcase
      // the top positive field is legal only at zero line and time
      if (!neg && fmag == fmax && $urandom_range(0, 1) == 1) begin
         lmag = 0;
         tmag = 0;
      end
      if (neg) begin
         fld = flt_pkg::FieldW'(-fmag);
         ln = flt_pkg::LineW'(-lmag);
         tm = flt_pkg::TimeW'(-tmag);
      end else begin
         fld = flt_pkg::FieldW'(fmag);
         ln = flt_pkg::LineW'(lmag);
         tm = flt_pkg::TimeW'(tmag);
      end
      // break the sign agreement of one part
      if (kind == 9) begin
         case ($urandom_range(0, 2))
            0: fld = -fld;
            1: ln = -ln;
            default: tm = -tm;
         endcase
      end
   endfunction

   // Stall the result channel for a random gap before each word.
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
      end
   end

   // Stimulus and verdict.
   initial begin
      logic signed [flt_pkg::FieldW-1:0] fld;
      logic signed [flt_pkg::LineW-1:0]  ln;
      logic signed [flt_pkg::TimeW-1:0]  tm;
      flt_pkg::std_type                  std;
      no_idle = 1'b0;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= 1'b0;
      req_if.valid <= 1'b0;
      req_if.field <= '0;
      req_if.line <= '0;
      req_if.time_tenth_ns <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 625-line limits: zero, frame edges, time limit, mixed sign, bad fields
      send_offset(0, 0, 0);
      send_offset(0, 312, 0);
      send_offset(0, 313, 0);
      send_offset(0, -311, 0);
      send_offset(0, -312, 0);
      send_offset(1, 311, 639999);
      send_offset(1, 312, 0);
      send_offset(2, 312, 640000);
      send_offset(3, 311, 1);
      send_offset(4, 0, 0);
      send_offset(4, 0, 1);
      send_offset(4, 1, 0);
      send_offset(-1, -312, -639999);
      send_offset(-2, -311, -640000);
      send_offset(-3, -312, -640001);
      send_offset(0, 0, -1);
      send_offset(1, -1, 5);
      send_offset(7, 1023, 1048575);
      send_offset(-8, -1024, -1048576);
      send_offset(5, 0, 0);

      // 525-line limits
      write_standard(flt_pkg::STD_525);
      send_offset(2, 0, 0);
      send_offset(2, 0, 1);
      send_offset(1, 261, 635554);
      send_offset(1, 262, 0);
      send_offset(-1, -262, -635555);
      send_offset(0, -261, -635556);
      send_offset(0, 262, 0);
      send_offset(-2, 0, 0);

      // random phases, alternating the standard between them
      for (int phase = 0; phase < 8; phase++) begin
         std = (phase % 2 == 0) ? flt_pkg::STD_625 : flt_pkg::STD_525;
         write_standard(std);
         no_idle = (phase == 2) || ($urandom_range(0, 3) == 0);
         repeat (50) begin
            pick_offset(std, fld, ln, tm);
            send_offset(fld, ln, tm);
         end
         no_idle = 1'b0;
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("field_line_time_to_samples test passed");
      end else begin
         $display("field_line_time_to_samples test failed");
      end
      $finish;
   end

   // Bound the run.
   initial begin
      #2ms;
      $display("field_line_time_to_samples test failed");
      $finish;
   end

endmodule
